@@ rtl/smcp_pkg.sv @@
// Package for the serial move command parser.
// Holds the parse phase and event codes, the line state and result types,
// and small character class helpers. No dependencies.
package smcp_pkg;

    // phase of the "x %d y %d z %d" matcher
    typedef enum logic [3:0] {
        PH_X     = 4'd0,
        PH_PRE_X = 4'd1,
        PH_NUM_X = 4'd2,
        PH_Y     = 4'd3,
        PH_PRE_Y = 4'd4,
        PH_NUM_Y = 4'd5,
        PH_Z     = 4'd6,
        PH_PRE_Z = 4'd7,
        PH_NUM_Z = 4'd8,
        PH_DONE  = 4'd9,
        PH_FAIL  = 4'd10
    } phase_t;

    // kind of a result item
    typedef enum logic [2:0] {
        EV_MOVE      = 3'd0,
        EV_INIT      = 3'd1,
        EV_BUF_OVF   = 3'd2,
        EV_QUEUE_OVF = 3'd3,
        EV_BAD_LINE  = 3'd4
    } event_kind_t;

    localparam logic [7:0] CHAR_NEWLINE = 8'd10;
    localparam logic [7:0] CHAR_NUL     = 8'd0;
    localparam logic [7:0] CHAR_SPACE   = 8'd32;
    localparam logic [7:0] CHAR_TAB     = 8'd9;
    localparam logic [7:0] CHAR_CR      = 8'd13;
    localparam logic [7:0] CHAR_PLUS    = 8'h2B;
    localparam logic [7:0] CHAR_MINUS   = 8'h2D;
    localparam logic [7:0] CHAR_ZERO    = 8'h30;
    localparam logic [7:0] CHAR_NINE    = 8'h39;
    localparam logic [7:0] CHAR_X       = 8'h78;
    localparam logic [7:0] CHAR_Y       = 8'h79;
    localparam logic [7:0] CHAR_Z       = 8'h7A;

    // letters of the init line, and progress codes of that match
    localparam logic [7:0] INIT_WORD [4] = '{8'h69, 8'h6E, 8'h69, 8'h74};
    localparam logic [2:0] INIT_DONE = 3'd4;
    localparam logic [2:0] INIT_FAIL = 3'd7;

    // everything the parser keeps between bytes of one line
    typedef struct packed {
        logic [6:0]  len;
        phase_t      phase;
        logic [2:0]  init;
        logic        neg;
        logic        digit;
        logic [31:0] acc;
        logic [31:0] vx;
        logic [31:0] vy;
        logic        ended;
    } line_state_t;

    localparam line_state_t LINE_CLEAR = '{
        len: 7'd0, phase: PH_X, init: 3'd0, neg: 1'b0, digit: 1'b0,
        acc: 32'd0, vx: 32'd0, vy: 32'd0, ended: 1'b0
    };

    // payload of one result item
    typedef struct packed {
        event_kind_t        kind;
        logic signed [31:0] x;
        logic signed [31:0] y;
        logic signed [31:0] z;
    } result_t;

    function automatic logic is_space(logic [7:0] c);
        return (c == CHAR_SPACE) || ((c >= CHAR_TAB) && (c <= CHAR_CR));
    endfunction

    function automatic logic is_digit(logic [7:0] c);
        return (c >= CHAR_ZERO) && (c <= CHAR_NINE);
    endfunction

endpackage

@@ rtl/smcp_parser.sv @@
// Line state registers and the per-byte parse step of the move parser.
// Depends on smcp_pkg for the state, phase and result types.
module smcp_parser
    import smcp_pkg::*;
#(
    parameter int BUF_SIZE    = 64,
    parameter int QUEUE_DEPTH = 16
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        step_en,
    input  logic [7:0]  char_byte,
    input  logic [7:0]  queued_moves,
    output logic        has_result,
    output result_t     result
);

    localparam logic [6:0] LEN_MAX  = 7'(BUF_SIZE - 1);
    localparam logic [7:0] Q_LIMIT  = 8'(QUEUE_DEPTH);

    line_state_t st_reg;
    line_state_t st_next;

    // accumulated number with its sign applied
    function automatic logic [31:0] signed_value(line_state_t s);
        return s.neg ? (~s.acc + 32'd1) : s.acc;
    endfunction

    // one nonzero byte through the pattern matcher
    function automatic line_state_t feed_byte(line_state_t s, logic [7:0] c);
        line_state_t r;
        phase_t      ph;
        phase_t      num_ph;
        logic        go;
        r  = s;
        ph = s.phase;
        go = 1'b1;
        if (ph == PH_NUM_X || ph == PH_NUM_Y || ph == PH_NUM_Z)
        begin
            go = 1'b0;
            if (is_digit(c))
            begin
                r.acc   = (s.acc << 3) + (s.acc << 1) + {28'd0, c[3:0]};
                r.digit = 1'b1;
            end
            else if (!s.digit)
            begin
                r.phase = PH_FAIL;
            end
            else if (ph == PH_NUM_Z)
            begin
                r.phase = PH_DONE;
            end
            else if (ph == PH_NUM_X)
            begin
                r.vx = signed_value(s);
                ph   = PH_Y;
                go   = 1'b1;
            end
            else
            begin
                r.vy = signed_value(s);
                ph   = PH_Z;
                go   = 1'b1;
            end
            r.phase = go ? ph : r.phase;
        end
        if (go)
        begin
            num_ph = (ph == PH_PRE_X) ? PH_NUM_X : (ph == PH_PRE_Y) ? PH_NUM_Y : PH_NUM_Z;
            unique case (ph)
                PH_X:
                begin
                    r.phase = (c == CHAR_X) ? PH_PRE_X : PH_FAIL;
                end
                PH_Y:
                begin
                    if (!is_space(c))
                        r.phase = (c == CHAR_Y) ? PH_PRE_Y : PH_FAIL;
                end
                PH_Z:
                begin
                    if (!is_space(c))
                        r.phase = (c == CHAR_Z) ? PH_PRE_Z : PH_FAIL;
                end
                PH_PRE_X, PH_PRE_Y, PH_PRE_Z:
                begin
                    if (!is_space(c))
                    begin
                        r.neg   = 1'b0;
                        r.digit = 1'b0;
                        r.acc   = 32'd0;
                        if (c == CHAR_PLUS)
                        begin
                            r.phase = num_ph;
                        end
                        else if (c == CHAR_MINUS)
                        begin
                            r.neg   = 1'b1;
                            r.phase = num_ph;
                        end
                        else if (is_digit(c))
                        begin
                            r.acc   = {28'd0, c[3:0]};
                            r.digit = 1'b1;
                            r.phase = num_ph;
                        end
                        else
                        begin
                            r.phase = PH_FAIL;
                        end
                    end
                end
                default:
                begin
                    r.phase = ph;
                end
            endcase
        end
        return r;
    endfunction

    // end of string: a third number that ends here is complete
    function automatic phase_t finish_phase(line_state_t s);
        if (s.phase == PH_NUM_Z && s.digit)
            return PH_DONE;
        else if (s.phase != PH_DONE)
            return PH_FAIL;
        else
            return PH_DONE;
    endfunction

    // next line state and result item for the byte in the input register
    always_comb
    begin
        line_state_t fed;
        st_next    = st_reg;
        has_result = 1'b0;
        result     = '{kind: EV_BAD_LINE, x: 32'sd0, y: 32'sd0, z: 32'sd0};
        fed        = feed_byte(st_reg, char_byte);
        if (st_reg.len >= LEN_MAX)
        begin
            st_next     = LINE_CLEAR;
            has_result  = 1'b1;
            result.kind = EV_BUF_OVF;
        end
        else if (char_byte != CHAR_NEWLINE)
        begin
            st_next.len = st_reg.len + 7'd1;
            if (!st_reg.ended)
            begin
                if (char_byte == CHAR_NUL)
                begin
                    st_next.ended = 1'b1;
                    st_next.phase = finish_phase(st_reg);
                end
                else
                begin
                    st_next      = fed;
                    st_next.len  = st_reg.len + 7'd1;
                    if (st_reg.init < INIT_DONE && char_byte == INIT_WORD[st_reg.init[1:0]])
                        st_next.init = st_reg.init + 3'd1;
                    else
                        st_next.init = INIT_FAIL;
                end
            end
        end
        else
        begin
            st_next    = LINE_CLEAR;
            has_result = 1'b1;
            if (queued_moves > Q_LIMIT)
            begin
                result.kind = EV_QUEUE_OVF;
            end
            else if (!st_reg.ended && st_reg.init == INIT_DONE)
            begin
                result.kind = EV_INIT;
            end
            else
            begin
                if (!st_reg.ended)
                    fed.phase = finish_phase(fed);
                else
                    fed = st_reg;
                if (fed.phase == PH_DONE)
                begin
                    result.kind = EV_MOVE;
                    result.x    = fed.vx;
                    result.y    = fed.vy;
                    result.z    = signed_value(fed);
                end
            end
        end
    end

    // line state register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            st_reg <= LINE_CLEAR;
        else if (step_en)
            st_reg <= st_next;
    end

endmodule

@@ rtl/serial_move_command_parser.sv @@
// Top level of the serial move command parser: input register, parse
// step and result register. Depends on smcp_pkg and smcp_parser.
//
//  channel  | handshake               | payload
//  ---------+-------------------------+------------------------------------
//  byte     | byte_valid, byte_stall  | char_byte, queued_moves
//  event    | event_valid,event_stall | event_kind, steps_x/y/z
//
// one item per cycle while byte_stall is low; a byte's result, if any, is
// loaded into the result register when the parse step takes the byte
// the parse step is one pass of logic over the line state registers
// reset clears the line state and both valid flags; no clearing pass
// a stalled result blocks only a byte that would produce another result
module serial_move_command_parser
    import smcp_pkg::*;
#(
    parameter int BUF_SIZE    = 64,
    parameter int QUEUE_DEPTH = 16
)
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               byte_valid,
    output logic               byte_stall,
    input  logic [7:0]         char_byte,
    input  logic [7:0]         queued_moves,
    output logic               event_valid,
    input  logic               event_stall,
    output logic [2:0]         event_kind,
    output logic signed [31:0] steps_x,
    output logic signed [31:0] steps_y,
    output logic signed [31:0] steps_z
);

    logic       in_valid_reg;
    logic [7:0] in_char_reg;
    logic [7:0] in_queued_reg;
    logic       out_valid_reg;
    result_t    out_reg;
    logic       step_en;
    logic       has_result;
    result_t    result;

    // parse step runs when its result, if any, has somewhere to go
    assign step_en    = in_valid_reg && (!has_result || !out_valid_reg || !event_stall);
    assign byte_stall = in_valid_reg && !step_en;

    smcp_parser #(
        .BUF_SIZE    (BUF_SIZE),
        .QUEUE_DEPTH (QUEUE_DEPTH)
    ) u_parser (
        .clk          (clk),
        .rst_n        (rst_n),
        .step_en      (step_en),
        .char_byte    (in_char_reg),
        .queued_moves (in_queued_reg),
        .has_result   (has_result),
        .result       (result)
    );

    // input register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            in_valid_reg <= 1'b0;
        else if (!byte_stall)
            in_valid_reg <= byte_valid;
    end

    always_ff @(posedge clk)
    begin
        if (!byte_stall && byte_valid)
        begin
            in_char_reg   <= char_byte;
            in_queued_reg <= queued_moves;
        end
    end

    // result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (step_en && has_result)
            out_valid_reg <= 1'b1;
        else if (!event_stall)
            out_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (step_en && has_result)
            out_reg <= result;
    end

    assign event_valid = out_valid_reg;
    assign event_kind  = out_reg.kind;
    assign steps_x     = out_reg.x;
    assign steps_y     = out_reg.y;
    assign steps_z     = out_reg.z;

endmodule
